// ===== design/dns_response_record_extractor_unit_macros.svh =====
// ---------------------------------------------------------------------------
// dns response record extractor assertion macros
// assertion wrappers, empty when synthesised
// ---------------------------------------------------------------------------
`ifndef DNS_RESPONSE_RECORD_EXTRACTOR_UNIT_MACROS_SVH
`define DNS_RESPONSE_RECORD_EXTRACTOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DRX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DRX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DRX_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DRX_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/drx_pkg.sv =====
// ---------------------------------------------------------------------------
// drx_pkg
// shared types and constants of the dns response record extractor
// ---------------------------------------------------------------------------
`default_nettype none
package drx_pkg;
    typedef struct packed {
        logic        kind;
        logic [12:0] offset;
        logic [15:0] length;
        logic [31:0] ttl;
        logic [3:0]  rcode;
        logic [1:0]  status;
    } t_result;

    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] ST_SUCCESS = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_FAIL    = 2'd2;

    localparam logic CFG_CLASS = 1'b0;
    localparam logic CFG_TYPE  = 1'b1;

    localparam logic [3:0] PH_HEADER = 4'd0;
    localparam logic [3:0] PH_NAME   = 4'd1;
    localparam logic [3:0] PH_LABEL  = 4'd2;
    localparam logic [3:0] PH_PTR    = 4'd3;
    localparam logic [3:0] PH_QFIXED = 4'd4;
    localparam logic [3:0] PH_AFIXED = 4'd5;
    localparam logic [3:0] PH_RDATA  = 4'd6;
    localparam logic [3:0] PH_DONE   = 4'd7;
    localparam logic [3:0] PH_HALT   = 4'd8;

    localparam logic [7:0] PTR_MASK = 8'hc0;
    localparam int         QFIXED_BYTES = 4;
    localparam int         AFIXED_BYTES = 10;
endpackage
`default_nettype wire

// ===== design/dns_response_record_extractor_unit.sv =====
// ---------------------------------------------------------------------------
// dns_response_record_extractor_unit
// dns response parser reporting matching answer records and a summary
// ---------------------------------------------------------------------------
// message bytes come in on i_msg_byte/i_end_of_message with i_valid/o_ready,
// one byte per cycle. each answer whose class and type match the values in
// configuration registers 0 and 1 gives a record result; the byte flagged as
// end of message gives a final summary result with rcode and status.
// results leave on o_valid/i_ready through a four-entry queue, the earliest
// in the cycle after the byte that caused it. a byte is taken every cycle while
// the queue holds at most two results; the queue drain rate sets the pace
// when the receiver stalls, and o_ready falls until room returns.
// reset (synchronous, active low) empties the queue, sets both registers
// to 1 and starts a new message; taking the end-of-message byte also clears
// the parser. the user writes configuration while idle; nothing enforces it.
// ---------------------------------------------------------------------------
`default_nettype none
module dns_response_record_extractor_unit #(
    parameter int MAX_MESSAGE_BYTES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_msg_byte,
    input  wire logic        i_end_of_message,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_result_kind,
    output logic [12:0]      o_rdata_offset,
    output logic [15:0]      o_rdata_length,
    output logic [31:0]      o_record_ttl,
    output logic [3:0]       o_response_code,
    output logic [1:0]       o_parse_status
);
    logic take, rec_push, sum_push;
    drx_pkg::t_result rec, sum, head;

    assign take = i_valid && o_ready;

    drx_parser #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_parser (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_take(take), .i_byte(i_msg_byte), .i_eom(i_end_of_message),
        .o_rec_push(rec_push), .o_sum_push(sum_push), .o_rec(rec), .o_sum(sum)
    );

    drx_result_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push_a(rec_push), .i_data_a(rec),
        .i_push_b(sum_push), .i_data_b(sum),
        .o_room(o_ready), .o_valid, .i_ready, .o_data(head)
    );

    assign o_result_kind   = head.kind;
    assign o_rdata_offset  = head.offset;
    assign o_rdata_length  = head.length;
    assign o_record_ttl    = head.ttl;
    assign o_response_code = head.rcode;
    assign o_parse_status  = head.status;
endmodule
`default_nettype wire

// ===== design/drx_parser.sv =====
// ---------------------------------------------------------------------------
// drx_parser
// front part: walks the message byte by byte and emits result entries
// ---------------------------------------------------------------------------
`default_nettype none
`include "dns_response_record_extractor_unit_macros.svh"
module drx_parser #(
    parameter int MAX_MESSAGE_BYTES = 4096
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_idx,
    input  wire logic [15:0]     i_cfg_data,
    input  wire logic            i_take,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_eom,
    output logic                 o_rec_push,
    output logic                 o_sum_push,
    output drx_pkg::t_result     o_rec,
    output drx_pkg::t_result     o_sum
);
    localparam int PW = $clog2(MAX_MESSAGE_BYTES + 1);

    logic [15:0] r_class, r_type;
    logic [PW-1:0] r_pos, n_pos;
    logic [3:0]  r_ph, n_ph;
    logic [15:0] r_qleft, n_qleft, r_aleft, n_aleft;
    logic [7:0]  r_lbl, n_lbl;
    logic [3:0]  r_cnt, n_cnt;
    logic [71:0] r_fix, n_fix;
    logic [15:0] r_rd, n_rd;
    logic [3:0]  r_rc, n_rc;
    logic        r_match, n_match, r_fail, n_fail;
    logic        rec_hit;
    logic [15:0] f_type, f_class, f_size;
    logic [31:0] f_ttl;
    logic        ok_end;
    logic [PW:0] pos_inc;

    assign f_type  = r_fix[71:56];
    assign f_class = r_fix[55:40];
    assign f_ttl   = r_fix[39:8];
    assign f_size  = {r_fix[7:0], i_byte};
    assign pos_inc = {1'b0, r_pos} + 1'b1;

    always_comb begin
        n_pos = r_pos; n_ph = r_ph; n_qleft = r_qleft; n_aleft = r_aleft;
        n_lbl = r_lbl; n_cnt = r_cnt; n_fix = r_fix; n_rd = r_rd; n_rc = r_rc;
        n_match = r_match; n_fail = r_fail; rec_hit = 1'b0;
        if (r_ph != drx_pkg::PH_HALT) begin
            if ({1'b0, r_pos} >= (PW+1)'(MAX_MESSAGE_BYTES)) begin
                n_fail = 1'b1;
                n_ph = drx_pkg::PH_HALT;
            end else begin
                n_pos = pos_inc[PW-1:0];
                case (r_ph)
                    drx_pkg::PH_HEADER: begin
                        case (r_pos[3:0])
                            4'd3: n_rc = i_byte[3:0];
                            4'd4: n_qleft[15:8] = i_byte;
                            4'd5: n_qleft[7:0] = i_byte;
                            4'd6: n_aleft[15:8] = i_byte;
                            4'd7: n_aleft[7:0] = i_byte;
                            4'd11: n_ph = (r_qleft != 0 || r_aleft != 0) ?
                                drx_pkg::PH_NAME : drx_pkg::PH_DONE;
                            default: ;
                        endcase
                    end
                    drx_pkg::PH_NAME: begin
                        if (i_byte == 8'd0) begin
                            n_ph = (r_qleft != 0) ? drx_pkg::PH_QFIXED : drx_pkg::PH_AFIXED;
                            n_cnt = '0;
                        end else if ((i_byte & drx_pkg::PTR_MASK) == drx_pkg::PTR_MASK) begin
                            n_ph = drx_pkg::PH_PTR;
                        end else begin
                            n_lbl = i_byte;
                            n_ph = drx_pkg::PH_LABEL;
                        end
                    end
                    drx_pkg::PH_LABEL: begin
                        n_lbl = r_lbl - 8'd1;
                        if (r_lbl == 8'd1) n_ph = drx_pkg::PH_NAME;
                    end
                    drx_pkg::PH_PTR: begin
                        n_ph = (r_qleft != 0) ? drx_pkg::PH_QFIXED : drx_pkg::PH_AFIXED;
                        n_cnt = '0;
                    end
                    drx_pkg::PH_QFIXED: begin
                        n_cnt = r_cnt + 4'd1;
                        if (r_cnt == 4'(drx_pkg::QFIXED_BYTES - 1)) begin
                            n_cnt = '0;
                            n_qleft = r_qleft - 16'd1;
                            n_ph = (n_qleft != 0 || r_aleft != 0) ?
                                drx_pkg::PH_NAME : drx_pkg::PH_DONE;
                        end
                    end
                    drx_pkg::PH_AFIXED: begin
                        n_fix = {r_fix[63:0], i_byte};
                        n_cnt = r_cnt + 4'd1;
                        if (r_cnt == 4'(drx_pkg::AFIXED_BYTES - 1)) begin
                            n_cnt = '0;
                            n_aleft = r_aleft - 16'd1;
                            if (f_class == r_class && f_type == r_type) begin
                                rec_hit = 1'b1;
                                n_match = 1'b1;
                            end
                            if (f_size != 0) begin
                                n_rd = f_size;
                                n_ph = drx_pkg::PH_RDATA;
                            end else begin
                                n_ph = (n_aleft != 0) ? drx_pkg::PH_NAME : drx_pkg::PH_DONE;
                            end
                        end
                    end
                    drx_pkg::PH_RDATA: begin
                        n_rd = r_rd - 16'd1;
                        if (r_rd == 16'd1)
                            n_ph = (r_aleft != 0) ? drx_pkg::PH_NAME : drx_pkg::PH_DONE;
                    end
                    default: ;
                endcase
            end
        end
        ok_end = (n_ph == drx_pkg::PH_DONE) || (n_ph == drx_pkg::PH_RDATA && n_aleft == 0);
        if (i_eom && !ok_end) n_fail = 1'b1;
    end

    always_comb begin
        o_rec.kind   = drx_pkg::KIND_RECORD;
        o_rec.offset = 13'(pos_inc);
        o_rec.length = f_size;
        o_rec.ttl    = f_ttl;
        o_rec.rcode  = r_rc;
        o_rec.status = drx_pkg::ST_SUCCESS;
        o_sum.kind   = drx_pkg::KIND_SUMMARY;
        o_sum.offset = '0;
        o_sum.length = '0;
        o_sum.ttl    = '0;
        o_sum.rcode  = n_rc;
        o_sum.status = n_fail ? drx_pkg::ST_FAIL :
                       (n_match ? drx_pkg::ST_SUCCESS : drx_pkg::ST_NONE);
    end
    assign o_rec_push = i_take && rec_hit;
    assign o_sum_push = i_take && i_eom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class <= 16'd1; r_type <= 16'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == drx_pkg::CFG_CLASS) r_class <= i_cfg_data;
            else r_type <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_eom)) begin
            r_pos <= '0; r_ph <= drx_pkg::PH_HEADER; r_qleft <= '0; r_aleft <= '0;
            r_lbl <= '0; r_cnt <= '0; r_fix <= '0; r_rd <= '0; r_rc <= '0;
            r_match <= 1'b0; r_fail <= 1'b0;
        end else if (i_take) begin
            r_pos <= n_pos; r_ph <= n_ph; r_qleft <= n_qleft; r_aleft <= n_aleft;
            r_lbl <= n_lbl; r_cnt <= n_cnt; r_fix <= n_fix; r_rd <= n_rd; r_rc <= n_rc;
            r_match <= n_match; r_fail <= n_fail;
        end
    end

    `DRX_ASSERT_IMP(a_halt_fail, i_clk, i_rst_n, r_ph == drx_pkg::PH_HALT, r_fail)
    `DRX_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt < 4'(drx_pkg::AFIXED_BYTES))
    `DRX_ASSERT_NXT(a_eom_clear, i_clk, i_rst_n, i_take && i_eom,
        r_ph == drx_pkg::PH_HEADER && r_pos == '0)
endmodule
`default_nettype wire

// ===== design/drx_result_queue.sv =====
// ---------------------------------------------------------------------------
// drx_result_queue
// back part: four-entry result queue taking up to two entries a cycle
// ---------------------------------------------------------------------------
`default_nettype none
`include "dns_response_record_extractor_unit_macros.svh"
module drx_result_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push_a,
    input  wire drx_pkg::t_result i_data_a,
    input  wire logic            i_push_b,
    input  wire drx_pkg::t_result i_data_b,
    output logic                 o_room,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output drx_pkg::t_result     o_data
);
    drx_pkg::t_result r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt, n_cnt;
    logic       pop;
    logic [1:0] wp1;

    assign pop     = o_valid && i_ready;
    assign o_valid = r_cnt != 3'd0;
    assign o_data  = r_mem[r_rp];
    assign o_room  = r_cnt <= 3'd2;
    assign wp1     = i_push_a ? r_wp + 2'd1 : r_wp;
    assign n_cnt   = r_cnt + {2'b0, i_push_a} + {2'b0, i_push_b} - {2'b0, pop};

    always_ff @(posedge i_clk) begin
        if (i_push_a) r_mem[r_wp] <= i_data_a;
        if (i_push_b) r_mem[wp1] <= i_data_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= wp1 + {1'b0, i_push_b};
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= n_cnt;
        end
    end

    `DRX_ASSERT_IMP(a_no_over, i_clk, i_rst_n, i_push_a || i_push_b,
        r_cnt + {2'b0, i_push_a} + {2'b0, i_push_b} <= 3'd4 + {2'b0, pop})
    `DRX_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= 3'd4)
    `DRX_ASSERT_NXT(a_pop_cnt, i_clk, i_rst_n, pop && !i_push_a && !i_push_b,
        r_cnt == $past(r_cnt) - 3'd1)
endmodule
`default_nettype wire
